@@ hdl/assert_macros.svh @@
// Assertion macros shared by the parser files.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

@@ hdl/jhsp_pkg.sv @@
// Types and constants for the JPEG header segment parser.
// Depends on nothing.
package jhsp_pkg;
  typedef enum logic [3:0] {
    PH_IDLE, PH_MARK, PH_LENH, PH_LENL, PH_SOF, PH_DHT, PH_DQT, PH_SOS,
    PH_APP0, PH_SKIP, PH_SCAN, PH_SCANFF, PH_HALT
  } phase_t;
  typedef enum logic [2:0] {
    SEG_SOF, SEG_DHT, SEG_DQT, SEG_SOS, SEG_APP0, SEG_SKIP
  } seg_t;
  localparam logic [4:0] K_PREC = 5'd0, K_HEIGHT = 5'd1, K_WIDTH = 5'd2,
    K_COUNT = 5'd3, K_COMPID = 5'd4, K_SAMP = 5'd5, K_QTSEL = 5'd6,
    K_MCU = 5'd7, K_HCOUNT = 5'd8, K_HSYM = 5'd9, K_QENTRY = 5'd10,
    K_SCANSEL = 5'd11, K_VERSION = 5'd12, K_UNITS = 5'd13, K_XDENS = 5'd14,
    K_YDENS = 5'd15, K_THUMB = 5'd16, K_EOI = 5'd17, K_ERROR = 5'd18;
  localparam logic [1:0] E_NONE = 2'd0, E_SUBSAMP = 2'd1, E_YIQ = 2'd2,
    E_NOEOI = 2'd3;
  localparam logic [7:0] M_SOF0 = 8'hC0, M_DHT = 8'hC4, M_DQT = 8'hDB,
    M_SOS = 8'hDA, M_APP0 = 8'hE0, M_EOI = 8'hD9, B_FF = 8'hFF, B_00 = 8'h00;
  typedef struct packed {
    logic [4:0]  kind;
    logic [2:0]  tidx;
    logic [7:0]  eidx;
    logic [15:0] val;
    logic [1:0]  err;
    logic        last;
  } rec_t;
  typedef struct packed {
    logic [1:0] n;
    rec_t       r0;
    rec_t       r1;
    rec_t       r2;
  } batch_t;
endpackage

@@ hdl/jhsp_core.sv @@
// Parser state machine: consumes one byte per cycle while step is high, yields up to 3 records.
// Depends on jhsp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jhsp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              stream_last,
  output jhsp_pkg::batch_t  batch
);
  jhsp_pkg::phase_t phase, phase_next;
  logic [15:0] seg_rem, seg_rem_next;
  logic [7:0]  hi, hi_next;
  logic [4:0]  fpos, fpos_next;
  logic [7:0]  ctot, ctot_next, ccur, ccur_next;
  logic [7:0]  cid0, cid1, cid2, cid0_next, cid1_next, cid2_next;
  logic [7:0]  fsamp, fsamp_next;
  logic [11:0] symrem, symrem_next;
  logic [4:0]  lcur, lcur_next;
  logic [7:0]  scur, scur_next;
  logic [2:0]  tsel, tsel_next;
  logic        qwide, qwide_next;
  logic [6:0]  qcur, qcur_next;
  logic        ended, ended_next;
  jhsp_pkg::rec_t r [3];
  logic [1:0]  n;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jhsp_pkg::PH_IDLE;
      seg_rem <= '0; hi <= '0; fpos <= '0; ctot <= '0; ccur <= '0;
      cid0 <= '0; cid1 <= '0; cid2 <= '0; fsamp <= '0; symrem <= '0;
      lcur <= '0; scur <= '0; tsel <= '0; qwide <= 1'b0; qcur <= '0;
      ended <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      seg_rem <= seg_rem_next; hi <= hi_next; fpos <= fpos_next;
      ctot <= ctot_next; ccur <= ccur_next;
      cid0 <= cid0_next; cid1 <= cid1_next; cid2 <= cid2_next;
      fsamp <= fsamp_next; symrem <= symrem_next; lcur <= lcur_next;
      scur <= scur_next; tsel <= tsel_next; qwide <= qwide_next;
      qcur <= qcur_next; ended <= ended_next;
    end
  end

  function automatic jhsp_pkg::rec_t mk(logic [4:0] k, logic [2:0] t, logic [7:0] e,
                                        logic [15:0] v, logic [1:0] er);
    jhsp_pkg::rec_t x;
    x.kind = k; x.tidx = t; x.eidx = e; x.val = v; x.err = er; x.last = 1'b0;
    return x;
  endfunction

  always_comb begin
    logic [15:0] wide, len;
    logic [7:0]  b, cc1;
    logic [11:0] sr;
    logic [3:0]  sh, sv;
    logic        dispatch, halted;
    jhsp_pkg::phase_t ph;
    b = data_byte;
    wide = {hi, b};
    len = 16'd0; cc1 = 8'd0; sr = 12'd0; dispatch = 1'b0; halted = 1'b0;
    sh = fsamp[7:4]; sv = fsamp[3:0];
    ph = phase;
    phase_next = phase; seg_rem_next = seg_rem; hi_next = hi; fpos_next = fpos;
    ctot_next = ctot; ccur_next = ccur; cid0_next = cid0; cid1_next = cid1;
    cid2_next = cid2; fsamp_next = fsamp; symrem_next = symrem; lcur_next = lcur;
    scur_next = scur; tsel_next = tsel; qwide_next = qwide; qcur_next = qcur;
    ended_next = ended;
    n = 2'd0;
    for (int i = 0; i < 3; i++) r[i] = '0;
    unique case (phase)
      jhsp_pkg::PH_IDLE: if (b == jhsp_pkg::B_FF) phase_next = jhsp_pkg::PH_MARK;
      jhsp_pkg::PH_MARK: dispatch = 1'b1;
      jhsp_pkg::PH_LENH: begin
        hi_next = b; phase_next = jhsp_pkg::PH_LENL;
      end
      jhsp_pkg::PH_LENL: begin
        len = wide;
        seg_rem_next = (len >= 16'd2) ? len - 16'd2 : 16'd0;
        fpos_next = '0;
        case (tsel)
          3'(jhsp_pkg::SEG_SOF):  phase_next = jhsp_pkg::PH_SOF;
          3'(jhsp_pkg::SEG_DHT):  phase_next = jhsp_pkg::PH_DHT;
          3'(jhsp_pkg::SEG_DQT):  phase_next = jhsp_pkg::PH_DQT;
          3'(jhsp_pkg::SEG_SOS):  phase_next = jhsp_pkg::PH_SOS;
          3'(jhsp_pkg::SEG_APP0): phase_next = jhsp_pkg::PH_APP0;
          default:                phase_next = jhsp_pkg::PH_SKIP;
        endcase
        tsel_next = '0;
        if (seg_rem_next == 16'd0)
          phase_next = (phase_next == jhsp_pkg::PH_SOS) ? jhsp_pkg::PH_SCAN
                                                         : jhsp_pkg::PH_IDLE;
      end
      jhsp_pkg::PH_SOF, jhsp_pkg::PH_DHT, jhsp_pkg::PH_DQT, jhsp_pkg::PH_SOS,
      jhsp_pkg::PH_APP0, jhsp_pkg::PH_SKIP: begin
        seg_rem_next = seg_rem - 16'd1;
        if (ph == jhsp_pkg::PH_SOF) begin
          case (fpos)
            5'd0: begin
              r[0] = mk(jhsp_pkg::K_PREC, 3'd0, 8'd0, {8'd0, b}, jhsp_pkg::E_NONE);
              n = 2'd1;
              fpos_next = 5'd1;
            end
            5'd1, 5'd3: begin hi_next = b; fpos_next = fpos + 5'd1; end
            5'd2: begin
              r[0] = mk(jhsp_pkg::K_HEIGHT, 3'd0, 8'd0, wide, jhsp_pkg::E_NONE);
              n = 2'd1;
              fpos_next = 5'd3;
            end
            5'd4: begin
              r[0] = mk(jhsp_pkg::K_WIDTH, 3'd0, 8'd0, wide, jhsp_pkg::E_NONE);
              n = 2'd1;
              fpos_next = 5'd5;
            end
            5'd5: begin
              ctot_next = b; ccur_next = '0;
              r[0] = mk(jhsp_pkg::K_COUNT, 3'd0, 8'd0, {8'd0, b}, jhsp_pkg::E_NONE);
              n = 2'd1;
              fpos_next = (b != 8'd0) ? 5'd6 : 5'd9;
            end
            5'd6: begin
              if (ccur == 8'd0) cid0_next = b;
              if (ccur == 8'd1) cid1_next = b;
              if (ccur == 8'd2) cid2_next = b;
              r[0] = mk(jhsp_pkg::K_COMPID, ccur[2:0], 8'd0, {8'd0, b},
                        jhsp_pkg::E_NONE);
              n = 2'd1; fpos_next = 5'd7;
            end
            5'd7: begin
              if (ccur == 8'd0) fsamp_next = b;
              r[0] = mk(jhsp_pkg::K_SAMP, ccur[2:0], 8'd0, {8'd0, b},
                        jhsp_pkg::E_NONE);
              n = 2'd1; fpos_next = 5'd8;
            end
            5'd8: begin
              r[0] = mk(jhsp_pkg::K_QTSEL, ccur[2:0], 8'd0, {8'd0, b},
                        jhsp_pkg::E_NONE);
              n = 2'd1;
              cc1 = ccur + 8'd1; ccur_next = cc1;
              if (cc1 == ctot) begin
                fpos_next = 5'd9;
                if (ctot == 8'd3) begin
                  if (cid0 == 8'd1 && cid1 == 8'd2 && cid2 == 8'd3) begin
                    n = 2'd2;
                    if (sh == 4'd1 && sv == 4'd1)
                      r[1] = mk(jhsp_pkg::K_MCU, 3'd0, 8'd0, 16'h0808, jhsp_pkg::E_NONE);
                    else if (sh == 4'd2 && sv == 4'd1)
                      r[1] = mk(jhsp_pkg::K_MCU, 3'd0, 8'd0, 16'h1008, jhsp_pkg::E_NONE);
                    else if (sh == 4'd2 && sv == 4'd2)
                      r[1] = mk(jhsp_pkg::K_MCU, 3'd0, 8'd0, 16'h1010, jhsp_pkg::E_NONE);
                    else begin
                      r[1] = mk(jhsp_pkg::K_ERROR, 3'd0, 8'd0, 16'd0,
                                jhsp_pkg::E_SUBSAMP);
                      halted = 1'b1;
                    end
                  end else if (cid0 == 8'd1 && cid1 == 8'd4 && cid2 == 8'd5) begin
                    n = 2'd2;
                    r[1] = mk(jhsp_pkg::K_ERROR, 3'd0, 8'd0, 16'd0, jhsp_pkg::E_YIQ);
                    halted = 1'b1;
                  end
                end
              end else fpos_next = 5'd6;
            end
            default: ;
          endcase
        end else if (ph == jhsp_pkg::PH_DHT) begin
          if (fpos == 5'd0) begin
            tsel_next = {b[4], b[1:0]};
            lcur_next = '0; symrem_next = '0; scur_next = '0; fpos_next = 5'd1;
          end else if (fpos == 5'd1) begin
            r[0] = mk(jhsp_pkg::K_HCOUNT, tsel, {3'd0, lcur}, {8'd0, b},
                      jhsp_pkg::E_NONE);
            n = 2'd1;
            sr = symrem + {4'd0, b}; symrem_next = sr;
            lcur_next = lcur + 5'd1;
            if (lcur_next >= 5'd16) fpos_next = (sr != 12'd0) ? 5'd2 : 5'd0;
          end else begin
            r[0] = mk(jhsp_pkg::K_HSYM, tsel, scur, {8'd0, b}, jhsp_pkg::E_NONE);
            n = 2'd1;
            scur_next = scur + 8'd1;
            sr = symrem - 12'd1; symrem_next = sr;
            if (sr == 12'd0) fpos_next = 5'd0;
          end
        end else if (ph == jhsp_pkg::PH_DQT) begin
          if (fpos == 5'd0) begin
            qwide_next = (b[7:4] != 4'd0); tsel_next = b[2:0];
            qcur_next = '0; fpos_next = 5'd1;
          end else if (fpos == 5'd1 && qwide) begin
            hi_next = b; fpos_next = 5'd2;
          end else begin
            r[0] = mk(jhsp_pkg::K_QENTRY, tsel, {1'b0, qcur},
                      (fpos == 5'd2) ? wide : {8'd0, b}, jhsp_pkg::E_NONE);
            n = 2'd1;
            qcur_next = qcur + 7'd1;
            fpos_next = qcur_next[6] ? 5'd0 : 5'd1;
          end
        end else if (ph == jhsp_pkg::PH_SOS) begin
          if (fpos == 5'd0) begin
            ctot_next = b; ccur_next = '0;
            fpos_next = (b != 8'd0) ? 5'd1 : 5'd3;
          end else if (fpos == 5'd1) fpos_next = 5'd2;
          else if (fpos == 5'd2) begin
            r[0] = mk(jhsp_pkg::K_SCANSEL, ccur[2:0], 8'd0, {8'd0, b},
                      jhsp_pkg::E_NONE);
            n = 2'd1;
            cc1 = ccur + 8'd1; ccur_next = cc1;
            fpos_next = (cc1 == ctot) ? 5'd3 : 5'd1;
          end
        end else if (ph == jhsp_pkg::PH_APP0) begin
          case (fpos)
            5'd5, 5'd8, 5'd10, 5'd12: hi_next = b;
            5'd6: begin
              r[0] = mk(jhsp_pkg::K_VERSION, 3'd0, 8'd0, wide, jhsp_pkg::E_NONE);
              n = 2'd1;
            end
            5'd7: begin
              r[0] = mk(jhsp_pkg::K_UNITS, 3'd0, 8'd0, {8'd0, b}, jhsp_pkg::E_NONE);
              n = 2'd1;
            end
            5'd9: begin
              r[0] = mk(jhsp_pkg::K_XDENS, 3'd0, 8'd0, wide, jhsp_pkg::E_NONE);
              n = 2'd1;
            end
            5'd11: begin
              r[0] = mk(jhsp_pkg::K_YDENS, 3'd0, 8'd0, wide, jhsp_pkg::E_NONE);
              n = 2'd1;
            end
            5'd13: begin
              r[0] = mk(jhsp_pkg::K_THUMB, 3'd0, 8'd0, wide, jhsp_pkg::E_NONE);
              n = 2'd1;
            end
            default: ;
          endcase
          if (fpos < 5'd14) fpos_next = fpos + 5'd1;
        end
        if (halted) phase_next = jhsp_pkg::PH_HALT;
        else if (seg_rem_next == 16'd0)
          phase_next = (ph == jhsp_pkg::PH_SOS) ? jhsp_pkg::PH_SCAN : jhsp_pkg::PH_IDLE;
      end
      jhsp_pkg::PH_SCAN: if (b == jhsp_pkg::B_FF) phase_next = jhsp_pkg::PH_SCANFF;
      jhsp_pkg::PH_SCANFF: begin
        if (b == jhsp_pkg::B_00 || (b >= 8'hD0 && b <= 8'hD7))
          phase_next = jhsp_pkg::PH_SCAN;
        else if (b != jhsp_pkg::B_FF) dispatch = 1'b1;
      end
      default: phase_next = jhsp_pkg::PH_HALT;
    endcase
    if (dispatch) begin
      if (b == jhsp_pkg::M_EOI) begin
        r[0] = mk(jhsp_pkg::K_EOI, 3'd0, 8'd0, 16'd0, jhsp_pkg::E_NONE); n = 2'd1;
        ended_next = 1'b1; phase_next = jhsp_pkg::PH_HALT;
      end else if (b == jhsp_pkg::B_FF) phase_next = jhsp_pkg::PH_MARK;
      else if (b == jhsp_pkg::B_00 || b == 8'h01 || (b >= 8'hD0 && b <= 8'hD8))
        phase_next = jhsp_pkg::PH_IDLE;
      else begin
        if (b == jhsp_pkg::M_SOF0) tsel_next = 3'(jhsp_pkg::SEG_SOF);
        else if (b == jhsp_pkg::M_DHT) tsel_next = 3'(jhsp_pkg::SEG_DHT);
        else if (b == jhsp_pkg::M_DQT) tsel_next = 3'(jhsp_pkg::SEG_DQT);
        else if (b == jhsp_pkg::M_SOS) tsel_next = 3'(jhsp_pkg::SEG_SOS);
        else if (b == jhsp_pkg::M_APP0) tsel_next = 3'(jhsp_pkg::SEG_APP0);
        else tsel_next = 3'(jhsp_pkg::SEG_SKIP);
        phase_next = jhsp_pkg::PH_LENH;
      end
    end
    if (stream_last && phase_next != jhsp_pkg::PH_HALT) begin
      r[n] = mk(jhsp_pkg::K_ERROR, 3'd0, 8'd0, 16'd0, jhsp_pkg::E_NOEOI);
      n = n + 2'd1;
      phase_next = jhsp_pkg::PH_HALT;
    end
    if (n != 2'd0) r[n - 2'd1].last = 1'b1;
    batch.n = n; batch.r0 = r[0]; batch.r1 = r[1]; batch.r2 = r[2];
  end

  `ASSERT_NEXT(a_halt_sticks, clk, rst, phase == jhsp_pkg::PH_HALT,
               phase == jhsp_pkg::PH_HALT)
  `ASSERT_IMPL(a_eoi_halts, clk, rst, ended, phase == jhsp_pkg::PH_HALT)
  `ASSERT_IMPL(a_rec_in_halt, clk, rst, phase == jhsp_pkg::PH_HALT, batch.n == 2'd0)
endmodule

@@ hdl/jpeg_header_segment_parser.sv @@
// JPEG header segment parser: one byte is taken per clock unless in_stall is
// high, and the records it causes (up to three) leave one per clock, unless
// out_stall holds them, from an output queue. The input stalls only while the
// queue lacks room for a byte's worst case, so the sustained rate is one byte
// per cycle whenever results are drained at least as fast as they arise.
`include "assert_macros.svh"
module jpeg_header_segment_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        stream_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  record_kind,
  output logic [2:0]  table_index,
  output logic [7:0]  entry_index,
  output logic [15:0] value,
  output logic [1:0]  error_code,
  output logic        last_in_run
);
  localparam int Depth = 8;
  jhsp_pkg::batch_t batch;
  jhsp_pkg::rec_t q [Depth];
  logic [2:0] wp, rp;
  logic [3:0] cnt, cnt_next;
  logic step, pop;

  assign in_stall = cnt > 4'(Depth - 3);
  assign step = in_valid && !in_stall;
  assign out_valid = cnt != 4'd0;
  assign pop = out_valid && !out_stall;

  jhsp_core u_core (
    .clk, .rst, .step, .data_byte, .stream_last, .batch
  );

  always_comb begin
    cnt_next = cnt + (step ? {2'd0, batch.n} : 4'd0) - (pop ? 4'd1 : 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (step) wp <= wp + 3'(batch.n);
      if (pop) rp <= rp + 3'd1;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (batch.n > 2'd0) q[wp] <= batch.r0;
      if (batch.n > 2'd1) q[wp + 3'd1] <= batch.r1;
      if (batch.n > 2'd2) q[wp + 3'd2] <= batch.r2;
    end
  end

  assign record_kind = q[rp].kind;
  assign table_index = q[rp].tidx;
  assign entry_index = q[rp].eidx;
  assign value       = q[rp].val;
  assign error_code  = q[rp].err;
  assign last_in_run = q[rp].last;

  `ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= 4'(Depth))
  `ASSERT_IMPL(a_ptr_gap, clk, rst, cnt < 4'(Depth), wp - rp == cnt[2:0])
  `ASSERT_NEXT(a_stall_pos, clk, rst, in_stall && !pop, in_stall)
endmodule

@@ tb/tb_top.sv @@
// Testbench for jpeg_header_segment_parser: byte stream in, decoded records out.
// Depends on jhsp_pkg; records are predicted per byte and checked in order.
`timescale 1ns / 100ps
module tb_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        stream_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  record_kind;
  logic [2:0]  table_index;
  logic [7:0]  entry_index;
  logic [15:0] value;
  logic [1:0]  error_code;
  logic        last_in_run;

  jpeg_header_segment_parser u_top (.*);

  always #6 clk = ~clk;

  localparam logic [5:0] NO_KIND = 6'h3F;
  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic [5:0] ek;
  } stim_t;

  stim_t byte_q[$];
  jhsp_pkg::rec_t record_q[$];
  jhsp_pkg::rec_t byte_recs[$];
  int    errors = 0;
  bit    feed_done = 0;

  // parser shadow state
  jhsp_pkg::phase_t ph;
  logic [15:0] seg_rem;
  logic [7:0]  hi_latch;
  logic [4:0]  fpos;
  logic [7:0]  comp_tot, comp_cur, samp0;
  logic [7:0]  comp_id [3];
  logic [11:0] sym_rem;
  logic [4:0]  len_cur;
  logic [7:0]  sym_cur;
  logic [2:0]  tsel;
  logic        qwide;
  logic [6:0]  q_cur;

  function automatic void emit(logic [4:0] k, logic [2:0] t, logic [7:0] e,
                               logic [15:0] v, logic [1:0] er);
    jhsp_pkg::rec_t r;
    if (byte_recs.size() >= 3) return;
    r.kind = k; r.tidx = t; r.eidx = e; r.val = v; r.err = er; r.last = 1'b0;
    byte_recs.push_back(r);
  endfunction

  function automatic void marker_dispatch(logic [7:0] b);
    if (b == jhsp_pkg::M_EOI) begin
      emit(jhsp_pkg::K_EOI, 3'd0, 8'd0, 16'd0, jhsp_pkg::E_NONE);
      ph = jhsp_pkg::PH_HALT;
    end else if (b == jhsp_pkg::B_FF) begin
      ph = jhsp_pkg::PH_MARK;
    end else if (b == 8'h00 || b == 8'h01 || (b >= 8'hD0 && b <= 8'hD8)) begin
      ph = jhsp_pkg::PH_IDLE;
    end else begin
      case (b)
        jhsp_pkg::M_SOF0: tsel = 3'(jhsp_pkg::SEG_SOF);
        jhsp_pkg::M_DHT:  tsel = 3'(jhsp_pkg::SEG_DHT);
        jhsp_pkg::M_DQT:  tsel = 3'(jhsp_pkg::SEG_DQT);
        jhsp_pkg::M_SOS:  tsel = 3'(jhsp_pkg::SEG_SOS);
        jhsp_pkg::M_APP0: tsel = 3'(jhsp_pkg::SEG_APP0);
        default:          tsel = 3'(jhsp_pkg::SEG_SKIP);
      endcase
      ph = jhsp_pkg::PH_LENH;
    end
  endfunction

  function automatic void frame_check();
    logic [3:0] h, v;
    h = samp0[7:4];
    v = samp0[3:0];
    if (comp_tot != 3) return;
    if (comp_id[0] == 1 && comp_id[1] == 2 && comp_id[2] == 3) begin
      if (h == 1 && v == 1) emit(jhsp_pkg::K_MCU, 3'd0, 8'd0, 16'h0808, jhsp_pkg::E_NONE);
      else if (h == 2 && v == 1)
        emit(jhsp_pkg::K_MCU, 3'd0, 8'd0, 16'h1008, jhsp_pkg::E_NONE);
      else if (h == 2 && v == 2)
        emit(jhsp_pkg::K_MCU, 3'd0, 8'd0, 16'h1010, jhsp_pkg::E_NONE);
      else begin
        emit(jhsp_pkg::K_ERROR, 3'd0, 8'd0, 16'd0, jhsp_pkg::E_SUBSAMP);
        ph = jhsp_pkg::PH_HALT;
      end
    end else if (comp_id[0] == 1 && comp_id[1] == 4 && comp_id[2] == 5) begin
      emit(jhsp_pkg::K_ERROR, 3'd0, 8'd0, 16'd0, jhsp_pkg::E_YIQ);
      ph = jhsp_pkg::PH_HALT;
    end
  endfunction

  function automatic void frame_byte(logic [7:0] b);
    logic [15:0] w;
    w = {hi_latch, b};
    case (fpos)
      0: begin emit(jhsp_pkg::K_PREC, 3'd0, 8'd0, {8'd0, b}, jhsp_pkg::E_NONE); fpos = 1; end
      1, 3: begin hi_latch = b; fpos++; end
      2: begin emit(jhsp_pkg::K_HEIGHT, 3'd0, 8'd0, w, jhsp_pkg::E_NONE); fpos = 3; end
      4: begin emit(jhsp_pkg::K_WIDTH, 3'd0, 8'd0, w, jhsp_pkg::E_NONE); fpos = 5; end
      5: begin
        comp_tot = b; comp_cur = 0;
        emit(jhsp_pkg::K_COUNT, 3'd0, 8'd0, {8'd0, b}, jhsp_pkg::E_NONE);
        fpos = (b != 0) ? 5'd6 : 5'd9;
      end
      6: begin
        if (comp_cur < 3) comp_id[comp_cur[1:0]] = b;
        emit(jhsp_pkg::K_COMPID, comp_cur[2:0], 8'd0, {8'd0, b}, jhsp_pkg::E_NONE);
        fpos = 7;
      end
      7: begin
        if (comp_cur == 0) samp0 = b;
        emit(jhsp_pkg::K_SAMP, comp_cur[2:0], 8'd0, {8'd0, b}, jhsp_pkg::E_NONE);
        fpos = 8;
      end
      8: begin
        emit(jhsp_pkg::K_QTSEL, comp_cur[2:0], 8'd0, {8'd0, b}, jhsp_pkg::E_NONE);
        comp_cur++;
        if (comp_cur == comp_tot) begin
          fpos = 9;
          frame_check();
        end else fpos = 6;
      end
      default: ;
    endcase
  endfunction

  function automatic void huff_byte(logic [7:0] b);
    if (fpos == 0) begin
      tsel = {b[4], b[1:0]};
      len_cur = 0; sym_rem = 0; sym_cur = 0; fpos = 1;
    end else if (fpos == 1) begin
      emit(jhsp_pkg::K_HCOUNT, tsel, {3'd0, len_cur}, {8'd0, b}, jhsp_pkg::E_NONE);
      sym_rem = sym_rem + {4'd0, b};
      len_cur++;
      if (len_cur >= 16) fpos = (sym_rem != 0) ? 5'd2 : 5'd0;
    end else begin
      emit(jhsp_pkg::K_HSYM, tsel, sym_cur, {8'd0, b}, jhsp_pkg::E_NONE);
      sym_cur++;
      sym_rem = sym_rem - 12'd1;
      if (sym_rem == 0) fpos = 0;
    end
  endfunction

  function automatic void quant_byte(logic [7:0] b);
    if (fpos == 0) begin
      qwide = (b[7:4] != 0);
      tsel = b[2:0]; q_cur = 0; fpos = 1;
      return;
    end
    if (fpos == 1 && qwide) begin
      hi_latch = b; fpos = 2;
      return;
    end
    if (fpos == 2)
      emit(jhsp_pkg::K_QENTRY, tsel, {1'b0, q_cur}, {hi_latch, b}, jhsp_pkg::E_NONE);
    else emit(jhsp_pkg::K_QENTRY, tsel, {1'b0, q_cur}, {8'd0, b}, jhsp_pkg::E_NONE);
    q_cur++;
    fpos = (q_cur >= 64) ? 5'd0 : 5'd1;
  endfunction

  function automatic void scan_hdr_byte(logic [7:0] b);
    if (fpos == 0) begin
      comp_tot = b; comp_cur = 0;
      fpos = (b != 0) ? 5'd1 : 5'd3;
    end else if (fpos == 1) begin
      fpos = 2;
    end else if (fpos == 2) begin
      emit(jhsp_pkg::K_SCANSEL, comp_cur[2:0], 8'd0, {8'd0, b}, jhsp_pkg::E_NONE);
      comp_cur++;
      fpos = (comp_cur == comp_tot) ? 5'd3 : 5'd1;
    end
  endfunction

  function automatic void jfif_byte(logic [7:0] b);
    logic [15:0] w;
    w = {hi_latch, b};
    case (fpos)
      5, 8, 10, 12: hi_latch = b;
      6:  emit(jhsp_pkg::K_VERSION, 3'd0, 8'd0, w, jhsp_pkg::E_NONE);
      7:  emit(jhsp_pkg::K_UNITS, 3'd0, 8'd0, {8'd0, b}, jhsp_pkg::E_NONE);
      9:  emit(jhsp_pkg::K_XDENS, 3'd0, 8'd0, w, jhsp_pkg::E_NONE);
      11: emit(jhsp_pkg::K_YDENS, 3'd0, 8'd0, w, jhsp_pkg::E_NONE);
      13: emit(jhsp_pkg::K_THUMB, 3'd0, 8'd0, w, jhsp_pkg::E_NONE);
      default: ;
    endcase
    if (fpos < 14) fpos++;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic l);
    jhsp_pkg::phase_t seg_ph;
    byte_recs.delete();
    case (ph)
      jhsp_pkg::PH_IDLE: if (b == jhsp_pkg::B_FF) ph = jhsp_pkg::PH_MARK;
      jhsp_pkg::PH_MARK: marker_dispatch(b);
      jhsp_pkg::PH_LENH: begin hi_latch = b; ph = jhsp_pkg::PH_LENL; end
      jhsp_pkg::PH_LENL: begin
        seg_rem = ({hi_latch, b} >= 16'd2) ? {hi_latch, b} - 16'd2 : 16'd0;
        fpos = 0;
        case (tsel)
          3'(jhsp_pkg::SEG_SOF):  ph = jhsp_pkg::PH_SOF;
          3'(jhsp_pkg::SEG_DHT):  ph = jhsp_pkg::PH_DHT;
          3'(jhsp_pkg::SEG_DQT):  ph = jhsp_pkg::PH_DQT;
          3'(jhsp_pkg::SEG_SOS):  ph = jhsp_pkg::PH_SOS;
          3'(jhsp_pkg::SEG_APP0): ph = jhsp_pkg::PH_APP0;
          default:                ph = jhsp_pkg::PH_SKIP;
        endcase
        tsel = 0;
        if (seg_rem == 0)
          ph = (ph == jhsp_pkg::PH_SOS) ? jhsp_pkg::PH_SCAN : jhsp_pkg::PH_IDLE;
      end
      jhsp_pkg::PH_SOF, jhsp_pkg::PH_DHT, jhsp_pkg::PH_DQT, jhsp_pkg::PH_SOS,
      jhsp_pkg::PH_APP0, jhsp_pkg::PH_SKIP: begin
        seg_ph = ph;
        seg_rem--;
        case (seg_ph)
          jhsp_pkg::PH_SOF:  frame_byte(b);
          jhsp_pkg::PH_DHT:  huff_byte(b);
          jhsp_pkg::PH_DQT:  quant_byte(b);
          jhsp_pkg::PH_SOS:  scan_hdr_byte(b);
          jhsp_pkg::PH_APP0: jfif_byte(b);
          default: ;
        endcase
        if (ph != jhsp_pkg::PH_HALT && seg_rem == 0)
          ph = (seg_ph == jhsp_pkg::PH_SOS) ? jhsp_pkg::PH_SCAN : jhsp_pkg::PH_IDLE;
      end
      jhsp_pkg::PH_SCAN: if (b == jhsp_pkg::B_FF) ph = jhsp_pkg::PH_SCANFF;
      jhsp_pkg::PH_SCANFF: begin
        if (b == jhsp_pkg::B_00 || (b >= 8'hD0 && b <= 8'hD7)) ph = jhsp_pkg::PH_SCAN;
        else if (b != jhsp_pkg::B_FF) marker_dispatch(b);
      end
      default: ph = jhsp_pkg::PH_HALT;
    endcase
    if (l && ph != jhsp_pkg::PH_HALT) begin
      emit(jhsp_pkg::K_ERROR, 3'd0, 8'd0, 16'd0, jhsp_pkg::E_NOEOI);
      ph = jhsp_pkg::PH_HALT;
    end
    if (byte_recs.size() > 0) byte_recs[byte_recs.size()-1].last = 1'b1;
    foreach (byte_recs[i]) record_q.push_back(byte_recs[i]);
  endfunction

  // stream building
  function automatic void put(logic [7:0] b);
    byte_q.push_back({b, 1'b0, NO_KIND});
  endfunction

  function automatic void put_segment(logic [7:0] mk, logic [7:0] pay[$]);
    int n;
    n = pay.size();
    if ($urandom_range(0, 5) == 0 && n > 0) n = $urandom_range(0, n - 1);
    put(jhsp_pkg::B_FF); put(mk);
    put(8'((n + 2) >> 8)); put(8'(n + 2));
    for (int i = 0; i < n; i++) put(pay[i]);
  endfunction

  // ending: 0 normal, 1 bad subsampling, 2 YIQ
  function automatic void put_frame(int ending);
    logic [7:0] pay[$];
    logic [7:0] ids[3];
    int n;
    n = (ending != 0) ? 3 : $urandom_range(0, 4);
    pay = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'(n)};
    if (ending == 1 || (ending == 0 && $urandom_range(0, 1))) ids = '{1, 2, 3};
    else if (ending == 2) ids = '{1, 4, 5};
    else ids = '{8'($urandom), 8'($urandom), 8'($urandom)};
    if (ending == 0 && n == 3 && ids[0] == 1 && ids[1] == 4 && ids[2] == 5) ids[0] = 7;
    for (int c = 0; c < n; c++) begin
      pay.push_back(c < 3 ? ids[c] : 8'($urandom));
      if (c == 0) begin
        if (ending == 1) pay.push_back(8'h12);
        else if (ids[0] == 1 && ids[1] == 2 && ids[2] == 3 && n == 3) begin
          case ($urandom_range(0, 2))
            0:       pay.push_back(8'h11);
            1:       pay.push_back(8'h21);
            default: pay.push_back(8'h22);
          endcase
        end else pay.push_back(8'($urandom));
      end else pay.push_back(8'($urandom));
      pay.push_back(8'($urandom_range(0, 3)));
    end
    if (ending != 0) begin
      put(jhsp_pkg::B_FF); put(jhsp_pkg::M_SOF0); put(8'h00); put(8'(pay.size() + 2));
      foreach (pay[i]) put(pay[i]);
    end else put_segment(jhsp_pkg::M_SOF0, pay);
  endfunction

  function automatic void put_huffman();
    logic [7:0] pay[$];
    int total;
    for (int t = 0; t < $urandom_range(1, 2); t++) begin
      total = 0;
      pay.push_back(8'($urandom));
      for (int i = 0; i < 16; i++) begin
        int c;
        c = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
        pay.push_back(8'(c));
        total += c;
      end
      for (int i = 0; i < total; i++) pay.push_back(8'($urandom));
    end
    put_segment(jhsp_pkg::M_DHT, pay);
  endfunction

  function automatic void put_quant();
    logic [7:0] pay[$];
    logic       wide;
    wide = 1'($urandom_range(0, 1));
    pay.push_back({wide ? 4'($urandom_range(1, 15)) : 4'h0, 4'($urandom)});
    for (int i = 0; i < (wide ? 128 : 64); i++) pay.push_back(8'($urandom));
    put_segment(jhsp_pkg::M_DQT, pay);
  endfunction

  function automatic void put_scan();
    logic [7:0] pay[$];
    int n;
    n = $urandom_range(0, 3);
    pay.push_back(8'(n));
    for (int c = 0; c < n; c++) begin
      pay.push_back(8'($urandom)); pay.push_back(8'($urandom));
    end
    repeat (3) pay.push_back(8'($urandom));
    put_segment(jhsp_pkg::M_SOS, pay);
    repeat ($urandom_range(3, 12)) begin
      case ($urandom_range(0, 7))
        0: begin put(jhsp_pkg::B_FF); put(jhsp_pkg::B_00); end
        1: begin put(jhsp_pkg::B_FF); put(8'hD0 + 8'($urandom_range(0, 7))); end
        2: begin put(jhsp_pkg::B_FF); put(jhsp_pkg::B_FF); put(jhsp_pkg::B_00); end
        default: put(8'($urandom_range(0, 254)));
      endcase
    end
  endfunction

  function automatic void put_jfif();
    logic [7:0] pay[$];
    pay = {8'h4A, 8'h46, 8'h49, 8'h46, 8'h00};
    repeat ($urandom_range(9, 12)) pay.push_back(8'($urandom));
    put_segment(jhsp_pkg::M_APP0, pay);
  endfunction

  function automatic void put_other();
    logic [7:0] pay[$];
    logic [7:0] mk[7];
    mk = '{8'hC1, 8'hC2, 8'hDD, 8'hE1, 8'hEF, 8'hFE, 8'hCC};
    repeat ($urandom_range(0, 4)) pay.push_back(8'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      put(jhsp_pkg::B_FF); put(mk[$urandom_range(0, 6)]); put(8'h00);
      put(8'($urandom_range(0, 1)));
    end else put_segment(mk[$urandom_range(0, 6)], pay);
  endfunction

  // stimulus
  initial begin
    stim_t directed[24];
    int ending, gap;
    directed = '{
      '{8'hFF, 1'b0, NO_KIND}, '{8'hD8, 1'b0, NO_KIND},
      '{8'hFF, 1'b0, NO_KIND}, '{8'hFF, 1'b0, NO_KIND}, '{jhsp_pkg::M_SOF0, 1'b0, NO_KIND},
      '{8'h00, 1'b0, NO_KIND}, '{8'h0B, 1'b0, NO_KIND},
      '{8'h08, 1'b0, 6'(jhsp_pkg::K_PREC)}, '{8'h00, 1'b0, NO_KIND},
      '{8'hFF, 1'b0, 6'(jhsp_pkg::K_HEIGHT)},
      '{8'hFF, 1'b0, NO_KIND}, '{8'hFF, 1'b0, 6'(jhsp_pkg::K_WIDTH)},
      '{8'h01, 1'b0, 6'(jhsp_pkg::K_COUNT)},
      '{8'h00, 1'b0, 6'(jhsp_pkg::K_COMPID)}, '{8'hFF, 1'b0, 6'(jhsp_pkg::K_SAMP)},
      '{8'h00, 1'b0, 6'(jhsp_pkg::K_QTSEL)},
      '{8'hFF, 1'b0, NO_KIND}, '{8'h00, 1'b0, NO_KIND},
      '{8'hFF, 1'b0, NO_KIND}, '{8'h01, 1'b0, NO_KIND},
      '{8'hFF, 1'b0, NO_KIND}, '{8'hDD, 1'b0, NO_KIND},
      '{8'h00, 1'b0, NO_KIND}, '{8'h01, 1'b0, NO_KIND}};
    foreach (directed[i]) byte_q.push_back(directed[i]);
    while (byte_q.size() < 130) begin
      case ($urandom_range(0, 9))
        0, 1: put_frame(0);
        2, 3: put_huffman();
        4:    put_quant();
        5, 6: put_scan();
        7:    put_jfif();
        8:    put_other();
        default: repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 254)));
      endcase
    end
    ending = $urandom_range(0, 3);
    if (ending == 0) begin put(jhsp_pkg::B_FF); put(jhsp_pkg::M_EOI); end
    else if (ending == 2) put_frame(1);
    else if (ending == 3) put_frame(2);
    put(8'($urandom));
    byte_q[byte_q.size()-1].l = 1'b1;

    ph = jhsp_pkg::PH_IDLE; seg_rem = 0; hi_latch = 0; fpos = 0; comp_tot = 0;
    comp_cur = 0;
    comp_id = '{0, 0, 0}; samp0 = 0; sym_rem = 0; len_cur = 0; sym_cur = 0;
    tsel = 0; qwide = 0; q_cur = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (byte_q[i]) begin
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 25);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= byte_q[i].b;
      stream_last <= byte_q[i].l;
      do begin
        @(negedge clk);
        gap = !in_stall;
        @(posedge clk);
      end while (!gap);
      parse_byte(byte_q[i].b, byte_q[i].l);
      if (byte_q[i].ek != NO_KIND &&
          (byte_recs.size() == 0 || 6'(byte_recs[0].kind) != byte_q[i].ek)) begin
        $error("record_kind: expected %0d, predicted otherwise", byte_q[i].ek);
        errors++;
      end
    end
    in_valid <= 1'b0;
    feed_done = 1;
    while (record_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  // receiver back-pressure
  initial begin
    int cyc;
    cyc = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 50) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
      end else if (cyc % 97 < 30) out_stall <= 1'b0;
      else if ($urandom_range(0, 19) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(8, 25)) @(posedge clk);
      end else out_stall <= ($urandom_range(0, 9) < 3);
    end
  end

  // result checking
  always @(negedge clk) begin
    jhsp_pkg::rec_t e;
    if (!rst && out_valid && !out_stall) begin
      if (record_q.size() == 0) begin
        $error("record with nothing expected: kind %0d", record_kind);
        errors++;
      end else begin
        e = record_q.pop_front();
        if (record_kind !== e.kind) begin
          $error("record_kind: expected %0d, got %0d", e.kind, record_kind); errors++;
        end
        if (table_index !== e.tidx) begin
          $error("table_index: expected %0d, got %0d", e.tidx, table_index); errors++;
        end
        if (entry_index !== e.eidx) begin
          $error("entry_index: expected %0d, got %0d", e.eidx, entry_index); errors++;
        end
        if (value !== e.val) begin
          $error("value: expected %0h, got %0h", e.val, value); errors++;
        end
        if (error_code !== e.err) begin
          $error("error_code: expected %0d, got %0d", e.err, error_code); errors++;
        end
        if (last_in_run !== e.last) begin
          $error("last_in_run: expected %0d, got %0d", e.last, last_in_run); errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end
endmodule
